>>> rtl/ciralu_pkg.sv
// ----------------------------------------------------------------------------
// ciralu_pkg
// Shared codes, types and helpers for the checked integer range ALU.
// ----------------------------------------------------------------------------
package ciralu_pkg;

	localparam int DIV_STEPS = 32;
	// input register, divider steps, lane output register, merge register
	localparam int TOTAL_LAT = DIV_STEPS + 3;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_MOD = 3'd4;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_OVF = 2'd1;
	localparam logic [1:0] ST_DOM = 2'd2;

	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] res;
		logic               ovf;
		logic               bzero;
	} lane_out_t;

endpackage

>>> rtl/checked_int_range_alu.sv
// ----------------------------------------------------------------------------
// checked_int_range_alu
// Checked ALU on signed 32-bit ranges: value, min and max lanes run side by
// side and a merge stage forms the status and the zeroed or saturated result.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy is never raised, the lanes are fully
// pipelined and the 32-step divider sets the latency.
// Reset clears only the valid pipeline; datapath registers are not reset.
// Results appear for one cycle with done and cannot be stalled.
module checked_int_range_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] a_val,
	input  logic signed [31:0] a_min,
	input  logic signed [31:0] a_max,
	input  logic signed [31:0] b_val,
	input  logic signed [31:0] b_min,
	input  logic signed [31:0] b_max,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] res_val,
	output logic signed [31:0] res_min,
	output logic signed [31:0] res_max
);

	logic [2:0]         min_op, max_op;
	logic signed [31:0] min_a, min_b, max_a, max_b;
	ciralu_pkg::lane_out_t val_o, min_o, max_o;

	logic [ciralu_pkg::TOTAL_LAT-1:0] vld_q;
	logic [1:0]         st_d, status_q;
	logic signed [31:0] rv_d, rmin_d, rmax_d, rv_q, rmin_q, rmax_q;

	assign busy = 1'b0;

	// route bounds: div crosses min/max, mod becomes b bound minus one
	always_comb begin
		min_op = req_type;
		max_op = req_type;
		min_a  = a_min;
		min_b  = b_min;
		max_a  = a_max;
		max_b  = b_max;
		case (req_type)
			ciralu_pkg::OP_DIV: begin
				min_b = b_max;
				max_b = b_min;
			end
			ciralu_pkg::OP_MOD: begin
				min_op = ciralu_pkg::OP_SUB;
				max_op = ciralu_pkg::OP_SUB;
				min_a  = b_min;
				max_a  = b_max;
				min_b  = 32'sd1;
				max_b  = 32'sd1;
			end
			default: ;
		endcase
	end

	ciralu_lane u_val (.clk(clk), .op(req_type), .a(a_val), .b(b_val), .out(val_o));
	ciralu_lane u_min (.clk(clk), .op(min_op), .a(min_a), .b(min_b), .out(min_o));
	ciralu_lane u_max (.clk(clk), .op(max_op), .a(max_a), .b(max_b), .out(max_o));

	always_comb begin
		rv_d   = val_o.res;
		rmin_d = min_o.res;
		rmax_d = max_o.res;
		case (val_o.op)
			ciralu_pkg::OP_ADD, ciralu_pkg::OP_SUB, ciralu_pkg::OP_MUL:
				st_d = val_o.ovf ? ciralu_pkg::ST_OVF : ciralu_pkg::ST_OK;
			ciralu_pkg::OP_DIV: begin
				st_d = (val_o.bzero || val_o.ovf) ? ciralu_pkg::ST_DOM : ciralu_pkg::ST_OK;
				if (min_o.bzero) begin
					rmin_d = ciralu_pkg::S32_MIN;
				end
				if (max_o.bzero) begin
					rmax_d = ciralu_pkg::S32_MAX;
				end
			end
			ciralu_pkg::OP_MOD:
				st_d = val_o.bzero ? ciralu_pkg::ST_DOM : ciralu_pkg::ST_OK;
			default: st_d = ciralu_pkg::ST_DOM;
		endcase
		// zero every field on error
		if (st_d != ciralu_pkg::ST_OK) begin
			rv_d   = '0;
			rmin_d = '0;
			rmax_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[ciralu_pkg::TOTAL_LAT-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		status_q <= st_d;
		rv_q     <= rv_d;
		rmin_q   <= rmin_d;
		rmax_q   <= rmax_d;
	end

	assign done    = vld_q[ciralu_pkg::TOTAL_LAT-1];
	assign status  = status_q;
	assign res_val = rv_q;
	assign res_min = rmin_q;
	assign res_max = rmax_q;

	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, ciralu_pkg::TOTAL_LAT))
		else $error("done without a matching accepted item");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ciralu_pkg::ST_OK) |-> (res_val == 0 && res_min == 0 && res_max == 0))
		else $error("error result not zeroed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ciralu_pkg::ST_OK || status == ciralu_pkg::ST_OVF ||
		          status == ciralu_pkg::ST_DOM))
		else $error("illegal status code");

endmodule

>>> rtl/ciralu_lane.sv
// ----------------------------------------------------------------------------
// ciralu_lane
// One arithmetic lane: add, sub, mul and a pipelined restoring divider that
// yields quotient and remainder. The result is saturated to 32 bits.
// ----------------------------------------------------------------------------
module ciralu_lane (
	input  logic                   clk,
	input  logic [2:0]             op,
	input  logic signed [31:0]     a,
	input  logic signed [31:0]     b,
	output ciralu_pkg::lane_out_t  out
);

	typedef struct packed {
		logic [2:0]         op;
		logic signed [63:0] prod;
		logic signed [32:0] sum;
		logic               neg_a;
		logic               neg_q;
		logic               bzero;
		logic [31:0]        r;
		logic [31:0]        n;
		logic [31:0]        d;
	} dstage_t;

	function automatic dstage_t div_step(input dstage_t p);
		dstage_t    nx;
		logic [32:0] rr;
		logic        ge;
		nx = p;
		rr = {p.r, p.n[31]};
		ge = (rr >= {1'b0, p.d});
		nx.r = ge ? 32'(rr - {1'b0, p.d}) : rr[31:0];
		nx.n = {p.n[30:0], ge};
		return nx;
	endfunction

	dstage_t dv_s [0:ciralu_pkg::DIV_STEPS];
	dstage_t st0;
	ciralu_pkg::lane_out_t out_q;

	logic signed [63:0] wide;
	logic signed [63:0] qmag;
	logic signed [63:0] rmag;
	logic               fits;
	ciralu_pkg::lane_out_t fin;

	always_comb begin
		st0.op    = op;
		st0.prod  = 64'(a) * 64'(b);
		st0.sum   = (op == ciralu_pkg::OP_SUB) ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
		st0.neg_a = a[31];
		st0.neg_q = a[31] ^ b[31];
		st0.bzero = (b == 32'sd0);
		st0.r     = '0;
		st0.n     = a[31] ? 32'(-a) : a;
		st0.d     = b[31] ? 32'(-b) : b;
	end

	always_ff @(posedge clk) begin
		dv_s[0] <= st0;
	end

	for (genvar k = 0; k < ciralu_pkg::DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk) begin
			dv_s[k+1] <= div_step(dv_s[k]);
		end
	end

	always_comb begin
		qmag = $signed({32'b0, dv_s[ciralu_pkg::DIV_STEPS].n});
		rmag = $signed({32'b0, dv_s[ciralu_pkg::DIV_STEPS].r});
		case (dv_s[ciralu_pkg::DIV_STEPS].op)
			ciralu_pkg::OP_ADD, ciralu_pkg::OP_SUB: wide = 64'(dv_s[ciralu_pkg::DIV_STEPS].sum);
			ciralu_pkg::OP_MUL: wide = dv_s[ciralu_pkg::DIV_STEPS].prod;
			ciralu_pkg::OP_DIV: wide = dv_s[ciralu_pkg::DIV_STEPS].neg_q ? -qmag : qmag;
			ciralu_pkg::OP_MOD: wide = dv_s[ciralu_pkg::DIV_STEPS].neg_a ? -rmag : rmag;
			default: wide = '0;
		endcase
		fits = (&wide[63:31]) | ~(|wide[63:31]);
		fin.op    = dv_s[ciralu_pkg::DIV_STEPS].op;
		fin.bzero = dv_s[ciralu_pkg::DIV_STEPS].bzero;
		fin.ovf   = ~fits;
		if (fits) begin
			fin.res = wide[31:0];
		end else begin
			fin.res = wide[63] ? ciralu_pkg::S32_MIN : ciralu_pkg::S32_MAX;
		end
	end

	always_ff @(posedge clk) begin
		out_q <= fin;
	end

	assign out = out_q;

endmodule

>>> tb/checked_int_range_alu_tb.sv
// ----------------------------------------------------------------------------
// checked_int_range_alu_tb
// Drives range operations through the checked ALU with random start gaps,
// predicts status, value and saturated bounds in 64-bit arithmetic and
// compares every done strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
module checked_int_range_alu_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 1330;
	localparam int WDOG_LIMIT = 20000;

	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] av, amin, amax, bv, bmin, bmax;
	} range_req_t;

	typedef struct packed {
		logic [1:0]         st;
		logic signed [31:0] v, lo, hi;
	} range_res_t;

	typedef struct {
		range_req_t req;
		bit         fixed;
		range_res_t want;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         req_type = '0;
	logic signed [31:0] a_val = '0, a_min = '0, a_max = '0;
	logic signed [31:0] b_val = '0, b_min = '0, b_max = '0;
	logic               done;
	logic [1:0]         status;
	logic signed [31:0] res_val, res_min, res_max;

	range_res_t pending_res[$];
	int         n_mismatch = 0;
	int         n_checked = 0;
	int         n_sent = 0;
	int         idle_cycles = 0;
	int         op_hits[8];

	always #2 clk = ~clk;

	checked_int_range_alu u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .a_val(a_val), .a_min(a_min), .a_max(a_max),
		.b_val(b_val), .b_min(b_min), .b_max(b_max), .done(done),
		.status(status), .res_val(res_val), .res_min(res_min), .res_max(res_max)
	);

	function automatic longint clamp32(longint x);
		if (x > longint'(ciralu_pkg::S32_MAX))
			return longint'(ciralu_pkg::S32_MAX);
		if (x < longint'(ciralu_pkg::S32_MIN))
			return longint'(ciralu_pkg::S32_MIN);
		return x;
	endfunction

	// 32-bit bound divide; the most negative over minus one saturates
	function automatic longint bound_div(longint n, longint d);
		return clamp32(n / d);
	endfunction

	function automatic range_res_t range_alu(range_req_t q);
		range_res_t r;
		longint av, amin, amax, bv, bmin, bmax, v, lo, hi;
		logic [1:0] st;
		av = q.av; amin = q.amin; amax = q.amax;
		bv = q.bv; bmin = q.bmin; bmax = q.bmax;
		st = ciralu_pkg::ST_OK; v = 0; lo = 0; hi = 0;
		case (q.op)
			ciralu_pkg::OP_ADD: begin
				v = av + bv; lo = clamp32(amin + bmin); hi = clamp32(amax + bmax);
			end
			ciralu_pkg::OP_SUB: begin
				v = av - bv; lo = clamp32(amin - bmin); hi = clamp32(amax - bmax);
			end
			ciralu_pkg::OP_MUL: begin
				v = av * bv; lo = clamp32(amin * bmin); hi = clamp32(amax * bmax);
			end
			ciralu_pkg::OP_DIV: begin
				if (bv == 0 || (av == longint'(ciralu_pkg::S32_MIN) && bv == -1)) begin
					st = ciralu_pkg::ST_DOM;
				end else begin
					v = av / bv;
					lo = (bmax == 0) ? longint'(ciralu_pkg::S32_MIN) : bound_div(amin, bmax);
					hi = (bmin == 0) ? longint'(ciralu_pkg::S32_MAX) : bound_div(amax, bmin);
				end
			end
			ciralu_pkg::OP_MOD: begin
				if (bv == 0) begin
					st = ciralu_pkg::ST_DOM;
				end else begin
					v = av % bv; lo = clamp32(bmin - 1); hi = clamp32(bmax - 1);
				end
			end
			default: st = ciralu_pkg::ST_DOM;
		endcase
		if (st == ciralu_pkg::ST_OK && (q.op == ciralu_pkg::OP_ADD
				|| q.op == ciralu_pkg::OP_SUB || q.op == ciralu_pkg::OP_MUL)
				&& v != clamp32(v))
			st = ciralu_pkg::ST_OVF;
		if (st != ciralu_pkg::ST_OK) begin
			v = 0; lo = 0; hi = 0;
		end
		r.st = st; r.v = v[31:0]; r.lo = lo[31:0]; r.hi = hi[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return ciralu_pkg::S32_MIN;
			1: return ciralu_pkg::S32_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd1;
			5, 6: return $signed(32'($urandom_range(0, 200)) - 32'sd100);
			7: return $signed(32'($urandom_range(0, 131070)) - 32'sd65535);
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic range_req_t rand_req();
		range_req_t q;
		q.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(0, 4));
		q.av = pick_word(); q.amin = pick_word(); q.amax = pick_word();
		q.bv = pick_word(); q.bmin = pick_word(); q.bmax = pick_word();
		return q;
	endfunction

	// send one item, with a random gap before it
	task automatic issue(range_req_t q, bit fixed, range_res_t want);
		int gap;
		range_res_t r;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
			: (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_type <= q.op; a_val <= q.av; a_min <= q.amin; a_max <= q.amax;
		b_val <= q.bv; b_min <= q.bmin; b_max <= q.bmax;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = range_alu(q);
		if (fixed && r != want)
			$display("note: hand value disagrees with prediction, op %0d", q.op);
		pending_res.push_back(fixed ? want : r);
		op_hits[q.op]++;
		n_sent++;
	endtask

	always @(posedge clk) begin
		range_res_t w;
		if (start && !busy || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (done) begin
			n_checked++;
			if (pending_res.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("result with nothing pending: st %0d val %0d", status, res_val);
			end else begin
				w = pending_res.pop_front();
				if (status !== w.st || res_val !== w.v || res_min !== w.lo
						|| res_max !== w.hi) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: want st %0d %0d [%0d,%0d], got st %0d %0d [%0d,%0d]",
							w.st, w.v, w.lo, w.hi, status, res_val, res_min, res_max);
				end
			end
		end
	end

	function automatic dir_row_t mk(logic [2:0] op, int av, int amin, int amax,
			int bv, int bmin, int bmax, bit fixed, logic [1:0] st, int v, int lo, int hi);
		dir_row_t d;
		d.req.op = op; d.req.av = av; d.req.amin = amin; d.req.amax = amax;
		d.req.bv = bv; d.req.bmin = bmin; d.req.bmax = bmax;
		d.fixed = fixed; d.want.st = st; d.want.v = v; d.want.lo = lo; d.want.hi = hi;
		return d;
	endfunction

	initial begin
		dir_row_t rows[$];
		range_res_t none;
		int mx, mn;
		mx = ciralu_pkg::S32_MAX; mn = ciralu_pkg::S32_MIN;
		none = '{st: ciralu_pkg::ST_OK, v: 0, lo: 0, hi: 0};
		rows.push_back(mk(ciralu_pkg::OP_ADD, 1, 0, 5, 2, 1, 3,
			1, ciralu_pkg::ST_OK, 3, 1, 8));
		rows.push_back(mk(ciralu_pkg::OP_ADD, mx, mx, mx, 1, 1, 1,
			1, ciralu_pkg::ST_OVF, 0, 0, 0));
		rows.push_back(mk(ciralu_pkg::OP_ADD, 0, mn, mx, 0, mn, mx,
			1, ciralu_pkg::ST_OK, 0, mn, mx));
		rows.push_back(mk(ciralu_pkg::OP_SUB, mn, 0, 0, 1, 0, 0,
			1, ciralu_pkg::ST_OVF, 0, 0, 0));
		rows.push_back(mk(ciralu_pkg::OP_SUB, 5, mn, mx, 3, 1, -1,
			1, ciralu_pkg::ST_OK, 2, mn, mx));
		rows.push_back(mk(ciralu_pkg::OP_MUL, mn, 0, 0, -1, 0, 0,
			1, ciralu_pkg::ST_OVF, 0, 0, 0));
		rows.push_back(mk(ciralu_pkg::OP_MUL, mx, mn, mx, -1, mn, mx,
			1, ciralu_pkg::ST_OK, -mx, mx, mx));
		rows.push_back(mk(ciralu_pkg::OP_MUL, 65536, 0, 0, 65536, 0, 0,
			1, ciralu_pkg::ST_OVF, 0, 0, 0));
		rows.push_back(mk(ciralu_pkg::OP_MUL, -7, 3, -4, 6, -2, 5,
			0, ciralu_pkg::ST_OK, 0, 0, 0));
		rows.push_back(mk(ciralu_pkg::OP_DIV, 7, 1, 1, 0, 1, 1,
			1, ciralu_pkg::ST_DOM, 0, 0, 0));
		rows.push_back(mk(ciralu_pkg::OP_DIV, mn, 0, 0, -1, 1, 1,
			1, ciralu_pkg::ST_DOM, 0, 0, 0));
		rows.push_back(mk(ciralu_pkg::OP_DIV, -7, 10, 10, 2, 0, 0,
			1, ciralu_pkg::ST_OK, -3, mn, mx));
		rows.push_back(mk(ciralu_pkg::OP_DIV, mx, mn, mn, -1, -1, -1,
			1, ciralu_pkg::ST_OK, -mx, mx, mx));
		rows.push_back(mk(ciralu_pkg::OP_DIV, 100, -50, 90, 7, -3, 9,
			0, ciralu_pkg::ST_OK, 0, 0, 0));
		rows.push_back(mk(ciralu_pkg::OP_MOD, 5, 0, 0, 0, 0, 0,
			1, ciralu_pkg::ST_DOM, 0, 0, 0));
		rows.push_back(mk(ciralu_pkg::OP_MOD, mn, 0, 0, -1, mn, mx,
			1, ciralu_pkg::ST_OK, 0, mn, mx - 1));
		rows.push_back(mk(ciralu_pkg::OP_MOD, -7, 0, 0, 3, 0, 5,
			1, ciralu_pkg::ST_OK, -1, -1, 4));
		rows.push_back(mk(3'd5, 1, 1, 1, 1, 1, 1, 1, ciralu_pkg::ST_DOM, 0, 0, 0));
		rows.push_back(mk(3'd6, 0, 0, 0, 0, 0, 0, 1, ciralu_pkg::ST_DOM, 0, 0, 0));
		rows.push_back(mk(3'd7, -1, -1, -1, -1, -1, -1, 1, ciralu_pkg::ST_DOM, 0, 0, 0));
		rows.push_back(mk(ciralu_pkg::OP_ADD, -1, -1, -1, -1, -1, -1,
			1, ciralu_pkg::ST_OK, -2, -2, -2));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			issue(rows[i].req, rows[i].fixed, rows[i].fixed ? rows[i].want : none);
		for (int i = 0; i < N_RANDOM; i++)
			issue(rand_req(), 1'b0, none);
		start <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (ciralu_pkg::TOTAL_LAT + 5) @(posedge clk);
		$display("%0d items sent, %0d results checked; add %0d sub %0d mul %0d div %0d mod %0d",
			n_sent, n_checked, op_hits[0], op_hits[1], op_hits[2], op_hits[3], op_hits[4]);
		$display("undefined opcodes %0d, mismatches %0d",
			op_hits[5] + op_hits[6] + op_hits[7], n_mismatch);
		if (n_mismatch == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// stop a run in which nothing moves
	initial begin
		wait (idle_cycles >= WDOG_LIMIT);
		$display("watchdog expired, %0d results pending", pending_res.size());
		$display("Test completed with failures");
		$finish;
	end
endmodule
